>>> rtl/ilid_pkg.sv
// types and constants shared by the indexed list store
// no dependencies
`default_nettype none

package ilid_pkg;

  localparam int IDX_W  = 16;
  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;
  localparam int EC_W   = 7;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 3'd0,
    OP_FRONT  = 3'd1,
    OP_BACK   = 3'd2,
    OP_INSERT = 3'd3,
    OP_DELETE = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_READ
  } fsm_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [IDX_W-1:0]  pos;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  rd_idx;
  } cell_cmd_t;

endpackage

`default_nettype wire

>>> rtl/ilid_cell.sv
// one list cell: holds one entry, shifts with its neighbours on insert and delete
// depends on ilid_pkg
`default_nettype none

module ilid_cell #(
  parameter int POS = 0
) (
  input  wire logic                       clk,
  input  wire ilid_pkg::cell_cmd_t        cmd,
  input  wire logic [ilid_pkg::DATA_W-1:0] val_left,
  input  wire logic [ilid_pkg::DATA_W-1:0] val_right,
  output logic      [ilid_pkg::DATA_W-1:0] val,
  output logic      [ilid_pkg::DATA_W-1:0] rd_data
);

  localparam logic [ilid_pkg::IDX_W-1:0] MY_POS = ilid_pkg::IDX_W'(POS);

  logic [ilid_pkg::DATA_W-1:0] val_r;
  logic [ilid_pkg::DATA_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (cmd.ins) begin
      if (cmd.pos == MY_POS) begin
        val_nxt = cmd.wdata;
      end else if (cmd.pos < MY_POS) begin
        val_nxt = val_left;
      end
    end else if (cmd.del) begin
      if (cmd.pos <= MY_POS) begin
        val_nxt = val_right;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val     = val_r;
  // only the addressed cell drives its entry into the read tree
  assign rd_data = (cmd.rd_idx == MY_POS) ? val_r : '0;

endmodule

`default_nettype wire

>>> rtl/ilid_rdtree.sv
// registered eight-way or-tree that gathers the addressed cell's entry
// depends on ilid_pkg
`default_nettype none

module ilid_rdtree #(
  parameter int CAPACITY = 64
) (
  input  wire logic                        clk,
  input  wire logic [ilid_pkg::DATA_W-1:0] din [CAPACITY],
  output logic      [ilid_pkg::DATA_W-1:0] dout
);

  localparam int LEVELS = ($clog2(CAPACITY) + 2) / 3;

  logic [ilid_pkg::DATA_W-1:0] lvl [1:LEVELS][CAPACITY];

  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    localparam int NC = (CAPACITY + (8 ** l) - 1) / (8 ** l);
    localparam int NN = (CAPACITY + (8 ** (l + 1)) - 1) / (8 ** (l + 1));
    for (genvar j = 0; j < NN; j++) begin : g_node
      logic [7:0][ilid_pkg::DATA_W-1:0] kids;
      logic [ilid_pkg::DATA_W-1:0]      acc;
      for (genvar k = 0; k < 8; k++) begin : g_kid
        if (j * 8 + k < NC) begin : g_on
          if (l == 0) begin : g_leaf
            assign kids[k] = din[j * 8 + k];
          end else begin : g_inner
            assign kids[k] = lvl[l][j * 8 + k];
          end
        end else begin : g_off
          assign kids[k] = '0;
        end
      end
      always_comb begin
        acc = '0;
        for (int k = 0; k < 8; k++) begin
          acc = acc | kids[k];
        end
      end
      always_ff @(posedge clk) begin
        lvl[l + 1][j] <= acc;
      end
    end
  end

  assign dout = lvl[LEVELS][0];

endmodule

`default_nettype wire

>>> rtl/indexed_list_insert_delete_top.sv
// Ordered list of up to CAPACITY signed 32-bit entries held in a chain of cells. Every
// insert, append, front insert or delete shifts the whole chain in the cycle the word is
// accepted, and one such request can be accepted every cycle while results are taken and
// no read is busy. A read that hits a held entry registers its index and passes through a
// registered eight-way or-tree of ceil(log2(CAPACITY)/3) levels, and the block takes no new
// request until its result is held; a read past the end answers at once. Every request
// gives exactly one result word, held in an output register.
// depends on ilid_pkg, ilid_cell, ilid_rdtree
`default_nettype none

module indexed_list_insert_delete_top #(
  parameter int CAPACITY = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic        [ilid_pkg::OP_W-1:0]   in_op,
  input  wire logic        [ilid_pkg::IDX_W-1:0]  in_index,
  input  wire logic signed [ilid_pkg::DATA_W-1:0] in_value,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed      [ilid_pkg::DATA_W-1:0] out_read_value,
  output logic             [ilid_pkg::ST_W-1:0]   out_status,
  output logic             [ilid_pkg::EC_W-1:0]   out_entry_count
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int LEVELS = ($clog2(CAPACITY) + 2) / 3;
  localparam int WAIT_W = $clog2(LEVELS + 1);

  ilid_pkg::fsm_t state_r, state_nxt;

  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [ilid_pkg::IDX_W-1:0]  rd_idx_r;
  logic [WAIT_W-1:0]           wait_r;

  logic                        out_valid_r;
  logic [ilid_pkg::DATA_W-1:0] out_read_value_r;
  logic [ilid_pkg::ST_W-1:0]   out_status_r;
  logic [ilid_pkg::EC_W-1:0]   out_entry_count_r;

  logic                        acc;
  logic                        rd_done;
  logic                        full;
  logic [ilid_pkg::IDX_W-1:0]  cnt16;
  logic                        dec_ins;
  logic                        dec_del;
  logic                        dec_go_read;
  logic [ilid_pkg::IDX_W-1:0]  dec_pos;
  logic [ilid_pkg::DATA_W-1:0] dec_rd;
  ilid_pkg::status_t           dec_st;
  logic [31:0]                 cnt_after_ext;
  logic [31:0]                 cnt_now_ext;

  ilid_pkg::cell_cmd_t         cmd;
  logic [ilid_pkg::DATA_W-1:0] cell_val [CAPACITY];
  logic [ilid_pkg::DATA_W-1:0] cell_rd  [CAPACITY];
  logic [ilid_pkg::DATA_W-1:0] tree_out;

  assign acc   = in_valid && in_ready;
  assign full  = count_r >= CNT_W'(CAPACITY);
  assign cnt16 = ilid_pkg::IDX_W'(count_r);

  // request decode
  always_comb begin
    dec_ins     = 1'b0;
    dec_del     = 1'b0;
    dec_go_read = 1'b0;
    dec_pos     = in_index;
    dec_rd      = '0;
    dec_st      = ilid_pkg::ST_OK;
    case (in_op)
      ilid_pkg::OP_READ: begin
        if (in_index < cnt16) begin
          dec_go_read = 1'b1;
        end else begin
          dec_rd = '1;
          dec_st = ilid_pkg::ST_RANGE;
        end
      end
      ilid_pkg::OP_FRONT: begin
        dec_pos = '0;
        if (full) dec_st = ilid_pkg::ST_FULL;
        else dec_ins = 1'b1;
      end
      ilid_pkg::OP_BACK: begin
        dec_pos = cnt16;
        if (full) dec_st = ilid_pkg::ST_FULL;
        else dec_ins = 1'b1;
      end
      ilid_pkg::OP_INSERT: begin
        if (in_index > cnt16) dec_st = ilid_pkg::ST_RANGE;
        else if (full) dec_st = ilid_pkg::ST_FULL;
        else dec_ins = 1'b1;
      end
      ilid_pkg::OP_DELETE: begin
        if (in_index >= cnt16) dec_st = ilid_pkg::ST_RANGE;
        else dec_del = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (acc && dec_ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (acc && dec_del) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // entry count reported modulo 128
  assign cnt_after_ext = 32'(count_nxt);
  assign cnt_now_ext   = 32'(count_r);

  // state machine: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ilid_pkg::FSM_IDLE: begin
        if (acc && dec_go_read) state_nxt = ilid_pkg::FSM_READ;
      end
      ilid_pkg::FSM_READ: begin
        if (wait_r == '0) state_nxt = ilid_pkg::FSM_IDLE;
      end
      default: state_nxt = ilid_pkg::FSM_IDLE;
    endcase
  end

  // state machine: outputs
  always_comb begin
    in_ready = 1'b0;
    rd_done  = 1'b0;
    case (state_r)
      ilid_pkg::FSM_IDLE: begin
        in_ready = !out_valid_r || out_ready;
      end
      ilid_pkg::FSM_READ: begin
        rd_done = (wait_r == '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ilid_pkg::FSM_IDLE;
      count_r     <= '0;
      wait_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (acc && dec_go_read) begin
        wait_r <= WAIT_W'(LEVELS);
      end else if (wait_r != '0) begin
        wait_r <= wait_r - WAIT_W'(1);
      end
      if ((acc && !dec_go_read) || rd_done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result word and read address
  always_ff @(posedge clk) begin
    if (acc && dec_go_read) begin
      rd_idx_r <= in_index;
    end
    if (acc && !dec_go_read) begin
      out_read_value_r  <= dec_rd;
      out_status_r      <= dec_st;
      out_entry_count_r <= cnt_after_ext[ilid_pkg::EC_W-1:0];
    end else if (rd_done) begin
      out_read_value_r  <= tree_out;
      out_status_r      <= ilid_pkg::ST_OK;
      out_entry_count_r <= cnt_now_ext[ilid_pkg::EC_W-1:0];
    end
  end

  always_comb begin
    cmd.ins    = acc && dec_ins;
    cmd.del    = acc && dec_del;
    cmd.pos    = dec_pos;
    cmd.wdata  = in_value;
    cmd.rd_idx = rd_idx_r;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ilid_pkg::DATA_W-1:0] left;
    logic [ilid_pkg::DATA_W-1:0] right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_val[i - 1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_val[i];
    end else begin : g_mid_r
      assign right = cell_val[i + 1];
    end
    ilid_cell #(
      .POS(i)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .val_left (left),
      .val_right(right),
      .val      (cell_val[i]),
      .rd_data  (cell_rd[i])
    );
  end

  ilid_rdtree #(
    .CAPACITY(CAPACITY)
  ) u_rdtree (
    .clk (clk),
    .din (cell_rd),
    .dout(tree_out)
  );

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_read_value_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_entry_count_r;

endmodule

`default_nettype wire

>>> rtl/ilid_checker.sv
// port-level checks for the indexed list store, bound to the top level
// depends on ilid_pkg and indexed_list_insert_delete_top
`default_nettype none

module ilid_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [ilid_pkg::DATA_W-1:0]   out_read_value,
  input wire logic [ilid_pkg::ST_W-1:0]     out_status,
  input wire logic [ilid_pkg::EC_W-1:0]     out_entry_count
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_read_value) && $stable(out_status)
      && $stable(out_entry_count))
    else $error("result word changed while stalled");

  // a new word is never taken while the result register is stuck
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !(out_valid && !out_ready))
    else $error("word accepted with result register blocked");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

  // a dropped insert reports no read data
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ilid_pkg::ST_FULL |-> out_read_value == '0)
    else $error("read value set on dropped insert");

endmodule

bind indexed_list_insert_delete_top ilid_checker u_ilid_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_read_value (out_read_value),
  .out_status     (out_status),
  .out_entry_count(out_entry_count)
);

`default_nettype wire
